[rtl/cpst_pkg.sv]
// ----------------------------------------------------------------------------
// cpst_pkg
// Shared types and constants of the contact pair state table.
// ----------------------------------------------------------------------------
package cpst_pkg;

    localparam int ID_W              = 16;
    localparam int DEF_TABLE_DEPTH   = 32;
    localparam int DEF_ID_BITS       = 16;
    localparam int MAX_RESULTS       = 32;

    typedef enum logic [1:0] {
        CMD_TEST   = 2'd0,
        CMD_DEACT  = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_BEGAN = 2'd1,
        EV_CONT  = 2'd2,
        EV_APART = 2'd3
    } t_event;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_FIN
    } t_state;

    typedef struct packed {
        logic [1:0]      command;
        logic [ID_W-1:0] id_a;
        logic [ID_W-1:0] id_b;
        logic            hit;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]      event_res;
        logic [ID_W-1:0] pair_low_id;
        logic [ID_W-1:0] pair_high_id;
        logic            overflow;
        logic            last;
    } t_out_beat;

endpackage

[rtl/cpst_if.sv]
// ----------------------------------------------------------------------------
// cpst_if
// Valid/ready channels carrying command beats and event beats.
// ----------------------------------------------------------------------------
interface cpst_in_if import cpst_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cpst_out_if import cpst_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/cpst_pair_ram.sv]
// ----------------------------------------------------------------------------
// cpst_pair_ram
// Pair ID storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module cpst_pair_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 32,
    parameter int AW    = 5
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/contact_pair_state_table_top.sv]
// Walk: test, deactivate and remove walk the pair memory through its single read
//   port, one entry per cycle while no deactivate apart beat stalls at the output;
//   clear skips the walk. A new command is taken only once the item's final beat
//   is loaded into the output register.
// Reset: synchronous; contact flags of all entries clear together, no sweep.
// ----------------------------------------------------------------------------
// contact_pair_state_table_top
// Collider pair contact table: began / continued / apart event tracking.
// ----------------------------------------------------------------------------
module contact_pair_state_table_top import cpst_pkg::*; #(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int ID_BITS     = DEF_ID_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cpst_in_if.sink     i_cmd,
    cpst_out_if.source  o_evt
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int ENT_W = 2 * ID_BITS;
    localparam int CNT_W = $clog2(MAX_RESULTS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_RESULTS);

    t_state r_state, n_state;

    logic [1:0]         r_cmd;
    logic [ID_BITS-1:0] r_key_lo, r_key_hi;
    logic               r_hit;

    logic [TABLE_DEPTH-1:0] r_valid;

    logic               r_iss_vld, r_cmp_vld;
    logic [IDX_W-1:0]   r_iss_idx, r_cmp_idx;

    logic               r_found, r_free;
    logic [IDX_W-1:0]   r_found_idx, r_free_idx;

    logic               r_pend_vld;
    logic [ID_BITS-1:0] r_pend_lo, r_pend_hi;
    logic [CNT_W-1:0]   r_cnt;

    logic               r_out_vld;
    t_out_beat          r_out;

    logic [ENT_W-1:0]   rd_data;
    logic [ID_BITS-1:0] ent_lo, ent_hi;
    logic               ent_v, ent_has_a, ent_match;
    logic               in_acc, out_free, deact_emit, stall, adv, walk_done;
    logic               rd_en, wr_en, fin_go, out_load_pend;
    logic [ID_BITS-1:0] in_a, in_b;
    t_out_beat          fin_beat;

    assign in_acc   = i_cmd.valid && i_cmd.ready;
    assign out_free = !r_out_vld || o_evt.ready;
    assign in_a     = i_cmd.data.id_a[ID_BITS-1:0];
    assign in_b     = i_cmd.data.id_b[ID_BITS-1:0];

    assign ent_lo    = rd_data[ENT_W-1 -: ID_BITS];
    assign ent_hi    = rd_data[ID_BITS-1:0];
    assign ent_v     = r_valid[r_cmp_idx];
    assign ent_has_a = (ent_lo == r_key_lo) || (ent_hi == r_key_lo);
    assign ent_match = ent_v && (ent_lo == r_key_lo) && (ent_hi == r_key_hi);

    assign deact_emit = r_cmp_vld && (r_cmd == CMD_DEACT) && ent_v && ent_has_a
                        && (r_cnt != CNT_MAX);
    assign stall      = deact_emit && r_pend_vld && !out_free;
    assign adv        = (r_state == S_WALK) && !stall;
    assign walk_done  = !r_iss_vld && !r_cmp_vld;
    assign rd_en      = adv && r_iss_vld;
    assign fin_go     = (r_state == S_FIN) && out_free;
    assign wr_en      = fin_go && (r_cmd == CMD_TEST) && !r_found && r_hit && r_free;
    assign out_load_pend = adv && deact_emit && r_pend_vld;

    cpst_pair_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (ENT_W),
        .AW    (IDX_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_free_idx),
        .i_wr_data ({r_key_lo, r_key_hi}),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_iss_idx),
        .o_rd_data (rd_data)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = (i_cmd.data.command == CMD_CLEAR) ? S_FIN : S_WALK;
                end
            end
            S_WALK: begin
                if (walk_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // final beat of the item
    always_comb begin
        fin_beat = '0;
        fin_beat.last = 1'b1;
        case (r_cmd)
            CMD_TEST: begin
                fin_beat.pair_low_id  = ID_W'(r_key_lo);
                fin_beat.pair_high_id = ID_W'(r_key_hi);
                if (r_found) begin
                    fin_beat.event_res = r_hit ? EV_CONT : EV_APART;
                end else if (r_hit) begin
                    fin_beat.event_res = EV_BEGAN;
                    fin_beat.overflow  = !r_free;
                end else begin
                    fin_beat.event_res = EV_NONE;
                end
            end
            CMD_DEACT: begin
                if (r_pend_vld) begin
                    fin_beat.event_res    = EV_APART;
                    fin_beat.pair_low_id  = ID_W'(r_pend_lo);
                    fin_beat.pair_high_id = ID_W'(r_pend_hi);
                end
            end
            default: fin_beat.event_res = EV_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_valid    <= '0;
            r_iss_vld  <= 1'b0;
            r_cmp_vld  <= 1'b0;
            r_found    <= 1'b0;
            r_free     <= 1'b0;
            r_pend_vld <= 1'b0;
            r_cnt      <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (in_acc) begin
                r_iss_vld  <= (i_cmd.data.command != CMD_CLEAR);
                r_cmp_vld  <= 1'b0;
                r_found    <= 1'b0;
                r_free     <= 1'b0;
                r_pend_vld <= 1'b0;
                r_cnt      <= '0;
                if (i_cmd.data.command == CMD_CLEAR) begin
                    r_valid <= '0;
                end
            end

            if (adv) begin
                r_cmp_vld <= r_iss_vld;
                if (r_iss_vld && (r_iss_idx == LAST_IDX)) begin
                    r_iss_vld <= 1'b0;
                end
                if (r_cmp_vld) begin
                    case (r_cmd)
                        CMD_TEST: begin
                            if (ent_match && !r_found) begin
                                r_found <= 1'b1;
                            end
                            if (!ent_v && !r_free) begin
                                r_free <= 1'b1;
                            end
                        end
                        CMD_DEACT: begin
                            if (ent_v && ent_has_a) begin
                                r_valid[r_cmp_idx] <= 1'b0;
                            end
                            if (deact_emit) begin
                                r_pend_vld <= 1'b1;
                                r_cnt      <= r_cnt + 1'b1;
                            end
                        end
                        CMD_REMOVE: begin
                            if (ent_has_a) begin
                                r_valid[r_cmp_idx] <= 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            if (fin_go && (r_cmd == CMD_TEST)) begin
                if (r_found && !r_hit) begin
                    r_valid[r_found_idx] <= 1'b0;
                end else if (wr_en) begin
                    r_valid[r_free_idx] <= 1'b1;
                end
            end

            if (out_load_pend || fin_go) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && o_evt.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd    <= i_cmd.data.command;
            r_hit    <= i_cmd.data.hit;
            r_iss_idx <= '0;
            r_key_lo <= ((i_cmd.data.command == CMD_TEST) && (in_b < in_a)) ? in_b : in_a;
            r_key_hi <= (in_b < in_a) ? in_a : in_b;
        end
        if (adv) begin
            r_cmp_idx <= r_iss_idx;
            if (r_iss_vld && (r_iss_idx != LAST_IDX)) begin
                r_iss_idx <= r_iss_idx + 1'b1;
            end
            if (r_cmp_vld && (r_cmd == CMD_TEST)) begin
                if (ent_match && !r_found) begin
                    r_found_idx <= r_cmp_idx;
                end
                if (!ent_v && !r_free) begin
                    r_free_idx <= r_cmp_idx;
                end
            end
            if (deact_emit) begin
                r_pend_lo <= ent_lo;
                r_pend_hi <= ent_hi;
            end
        end
        if (out_load_pend) begin
            r_out.event_res    <= EV_APART;
            r_out.pair_low_id  <= ID_W'(r_pend_lo);
            r_out.pair_high_id <= ID_W'(r_pend_hi);
            r_out.overflow     <= 1'b0;
            r_out.last         <= 1'b0;
        end else if (fin_go) begin
            r_out <= fin_beat;
        end
    end

    assign i_cmd.ready = (r_state == S_IDLE);
    assign o_evt.valid = r_out_vld;
    assign o_evt.data  = r_out;

endmodule

[rtl/cpst_chk.sv]
// ----------------------------------------------------------------------------
// cpst_chk
// Port-level checks of the contact pair state table, bound to the top level.
// ----------------------------------------------------------------------------
module cpst_chk import cpst_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      i_in_ready,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_out_beat i_out_data
);

    // one item in flight: no new command right after one is taken
    a_single_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("command accepted while previous item in flight");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_data)))
        else $error("stalled event beat changed");

    a_overflow_began: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_data.overflow) |->
        ((i_out_data.event_res == EV_BEGAN) && i_out_data.last))
        else $error("overflow on a beat other than a single began event");

    a_multi_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_data.last) |-> (i_out_data.event_res == EV_APART))
        else $error("non-final beat is not an apart event");

endmodule

bind contact_pair_state_table_top cpst_chk u_cpst_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_cmd.valid),
    .i_in_ready  (i_cmd.ready),
    .i_out_valid (o_evt.valid),
    .i_out_ready (o_evt.ready),
    .i_out_data  (o_evt.data)
);
